// ----- hw/rtl/dhfk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dhfk_pkg;

   // Widths of the shared datapath
   localparam int STEP_W     = 5;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 66;
   localparam int ENT_W      = 48;
   localparam int ACC_W      = 54;
   localparam int STORE_FRAC = 24;

   // Angle scaling and CORDIC constants
   localparam logic signed [MUL_W-1:0] TURN_SCALE      = 33'sd683565276;
   localparam logic signed [MUL_W-1:0] HALF_PI_Q30     = 33'sd1686629713;
   localparam logic signed [MUL_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

   // Saturation bounds of the stored product
   localparam logic signed [ACC_W-1:0] ROT_MAX = (54'sd1 <<< 25) - 54'sd1;
   localparam logic signed [ACC_W-1:0] ROT_MIN = -(54'sd1 <<< 25);
   localparam logic signed [ACC_W-1:0] S48_MAX = (54'sd1 <<< 47) - 54'sd1;
   localparam logic signed [ACC_W-1:0] S48_MIN = -(54'sd1 <<< 47);
   localparam logic signed [ENT_W-1:0] ONE_Q24 = 48'sd1 <<< STORE_FRAC;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_PH,
      OP_RED,
      OP_ZMUL,
      OP_ZSET,
      OP_ROT,
      OP_TRIG,
      OP_LKD,
      OP_LKM,
      OP_LKW,
      OP_MLO,
      OP_MHI,
      OP_ACC,
      OP_WR,
      OP_CP,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                load;
      logic                sel;
      logic [STEP_W-1:0]   step;
      logic [2:0]          n;
      logic [1:0]          i;
      logic [1:0]          j;
      logic [1:0]          v;
   } cmd_type;

   typedef struct packed {
      logic out_fire;
      logic last;
   } sts_type;

   typedef struct packed {
      logic               joint_type;
      logic signed [31:0] first_param;
      logic signed [31:0] second_param;
      logic signed [31:0] third_param;
      logic signed [31:0] joint_value;
      logic               last_link;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } rsp_type;

   // Truncated Q30 arctangent of 2^-idx
   function automatic logic signed [MUL_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
      logic signed [MUL_W-1:0] r;
      case (idx)
         5'd0:  r = 33'sh03243F6A8;
         5'd1:  r = 33'sh01DAC6705;
         5'd2:  r = 33'sh00FADBAFC;
         5'd3:  r = 33'sh007F56EA6;
         5'd4:  r = 33'sh003FEAB76;
         5'd5:  r = 33'sh001FFD55B;
         5'd6:  r = 33'sh000FFFAAA;
         5'd7:  r = 33'sh0007FFF55;
         5'd8:  r = 33'sh0003FFFEA;
         5'd9:  r = 33'sh0001FFFFD;
         5'd10: r = 33'sh0000FFFFF;
         5'd11: r = 33'sh00007FFFF;
         5'd12: r = 33'sh00003FFFF;
         5'd13: r = 33'sh00001FFFF;
         5'd14: r = 33'sh00000FFFF;
         5'd15: r = 33'sh000007FFF;
         5'd16: r = 33'sh000003FFF;
         5'd17: r = 33'sh000001FFF;
         5'd18: r = 33'sh000000FFF;
         5'd19: r = 33'sh0000007FF;
         5'd20: r = 33'sh0000003FF;
         5'd21: r = 33'sh0000001FF;
         5'd22: r = 33'sh0000000FF;
         5'd23: r = 33'sh00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dhfk_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dhfk_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dhfk_pkg::sts_type sts,
   output dhfk_pkg::cmd_type      cmd
);

   localparam int CNT_W = $clog2(CORDIC_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_PH, S_RED, S_ZMUL, S_ZSET, S_ROT, S_TRIG, S_LKD,
      S_LKM, S_LKW, S_MLO, S_MHI, S_ACC, S_WR, S_CP, S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic             sel_ff, sel_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [2:0]       n_ff, n_in;
   logic [1:0]       i_ff, i_in, j_ff, j_in, v_ff, v_in;

   assign req_ready = (state_ff == S_IDLE);

   // Sequence one link: two angles, link matrix, 12 dot products, then the result on a last link
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      v_in     = v_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_PH;
               sel_in   = 1'b0;
            end
         end
         S_PH:   state_in = S_RED;
         S_RED:  state_in = S_ZMUL;
         S_ZMUL: state_in = S_ZSET;
         S_ZSET: begin
            state_in = S_ROT;
            step_in  = '0;
         end
         S_ROT: begin
            if (step_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = S_TRIG;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_TRIG: begin
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = S_PH;
            end else begin
               state_in = S_LKD;
            end
         end
         S_LKD: begin
            state_in = S_LKM;
            n_in     = '0;
         end
         S_LKM: state_in = S_LKW;
         S_LKW: begin
            if (n_ff == 3'd5) begin
               state_in = S_MLO;
               i_in     = '0;
               j_in     = '0;
               v_in     = '0;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = S_LKM;
            end
         end
         S_MLO: state_in = S_MHI;
         S_MHI: state_in = S_ACC;
         S_ACC: begin
            if (v_ff == 2'd2) begin
               state_in = S_WR;
            end else begin
               v_in     = v_ff + 1'b1;
               state_in = S_MLO;
            end
         end
         S_WR: begin
            v_in = '0;
            if (j_ff == 2'd3) begin
               state_in = S_CP;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_MLO;
            end
         end
         S_CP: begin
            j_in = '0;
            if (i_ff == 2'd2) begin
               state_in = sts.last ? S_OUT : S_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_MLO;
            end
         end
         S_OUT: begin
            if (sts.out_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Decode state into the datapath command
   always_comb begin
      cmd      = '0;
      cmd.load = (state_ff == S_IDLE) && req_valid;
      cmd.sel  = sel_ff;
      cmd.step = dhfk_pkg::STEP_W'(step_ff);
      cmd.n    = n_ff;
      cmd.i    = i_ff;
      cmd.j    = j_ff;
      cmd.v    = v_ff;
      unique case (state_ff)
         S_IDLE:  cmd.op = dhfk_pkg::OP_NONE;
         S_PH:    cmd.op = dhfk_pkg::OP_PH;
         S_RED:   cmd.op = dhfk_pkg::OP_RED;
         S_ZMUL:  cmd.op = dhfk_pkg::OP_ZMUL;
         S_ZSET:  cmd.op = dhfk_pkg::OP_ZSET;
         S_ROT:   cmd.op = dhfk_pkg::OP_ROT;
         S_TRIG:  cmd.op = dhfk_pkg::OP_TRIG;
         S_LKD:   cmd.op = dhfk_pkg::OP_LKD;
         S_LKM:   cmd.op = dhfk_pkg::OP_LKM;
         S_LKW:   cmd.op = dhfk_pkg::OP_LKW;
         S_MLO:   cmd.op = dhfk_pkg::OP_MLO;
         S_MHI:   cmd.op = dhfk_pkg::OP_MHI;
         S_ACC:   cmd.op = dhfk_pkg::OP_ACC;
         S_WR:    cmd.op = dhfk_pkg::OP_WR;
         S_CP:    cmd.op = dhfk_pkg::OP_CP;
         S_OUT:   cmd.op = dhfk_pkg::OP_OUT;
         default: cmd.op = dhfk_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= 1'b0;
         step_ff  <= '0;
         n_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         v_ff     <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         step_ff  <= step_in;
         n_ff     <= n_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         v_ff     <= v_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dhfk_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dhfk_dp #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dhfk_pkg::cmd_type cmd,
   input  wire dhfk_pkg::req_type req_data,
   output dhfk_pkg::sts_type      sts,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output dhfk_pkg::rsp_type      rsp_data
);

   localparam int MW = dhfk_pkg::MUL_W;
   localparam int PW = dhfk_pkg::PROD_W;
   localparam int EW = dhfk_pkg::ENT_W;
   localparam int AW = dhfk_pkg::ACC_W;
   localparam int SH_D = dhfk_pkg::STORE_FRAC - FRAC_BITS;
   localparam int SH_A = FRAC_BITS + 6;
   localparam logic signed [PW-1:0] HALF_36 = 66'sd1 <<< 35;
   localparam logic signed [PW-1:0] HALF_A  = 66'sd1 <<< (SH_A - 1);
   localparam logic signed [PW-1:0] HALF_24 = 66'sd1 <<< 23;
   localparam logic signed [EW:0]   HALF_O  = (49'sd1 <<< SH_D) >>> 1;
   localparam logic signed [MW-1:0] HALF_6  = 33'sd32;
   localparam logic signed [EW:0]   P32_MAX = 49'sd2147483647;
   localparam logic signed [EW:0]   P32_MIN = -49'sd2147483648;

   // Link operands
   logic signed [31:0]    theta_ff, alpha_ff, a_ff, d_ff;
   logic                  last_ff;
   // Shared multiplier and CORDIC state
   logic signed [PW-1:0]  prod_ff;
   logic signed [30:0]    rr_ff;
   logic [1:0]            quad_ff;
   logic signed [MW-1:0]  x_ff, y_ff, z_ff;
   logic signed [MW-1:0]  st_ff, ct_ff, sa_ff, ca_ff;
   // Link matrix, running product, row buffer
   logic signed [EW-1:0]  lk_ff [12];
   logic signed [EW-1:0]  cm_ff [12];
   logic signed [EW-1:0]  row_ff [4];
   logic signed [EW-1:0]  lornd_ff;
   logic signed [AW-1:0]  acc_ff;
   logic                  rsp_valid_ff;
   dhfk_pkg::rsp_type     rsp_ff;

   logic signed [MW-1:0]  mul_a, mul_b, ang;
   logic signed [PW-1:0]  mul_p;
   logic [3:0]            cm_idx, lk_idx;
   logic signed [EW-1:0]  cm_rd, lk_rd, lkw_val, wr_val;
   logic signed [AW-1:0]  wr_sum, acc_in;
   logic [31:0]           ph, ph_off;
   logic signed [MW-1:0]  xs, ys, at;
   logic signed [MW-1:0]  c_q, s_q;
   logic                  out_fire;
   logic signed [31:0]    pos [3];

   assign cm_idx = {cmd.i, (cmd.op == dhfk_pkg::OP_WR) ? 2'd3 : cmd.v};
   assign lk_idx = {cmd.v, cmd.j};
   assign cm_rd  = cm_ff[cm_idx];
   assign lk_rd  = lk_ff[lk_idx];
   assign ang    = cmd.sel ? MW'(alpha_ff) : MW'(theta_ff);

   // Select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         dhfk_pkg::OP_PH: begin
            mul_a = ang;
            mul_b = dhfk_pkg::TURN_SCALE;
         end
         dhfk_pkg::OP_ZMUL: begin
            mul_a = MW'(rr_ff);
            mul_b = dhfk_pkg::HALF_PI_Q30;
         end
         dhfk_pkg::OP_LKM: begin
            case (cmd.n)
               3'd0: begin mul_a = -ca_ff; mul_b = st_ff; end
               3'd1: begin mul_a = sa_ff;  mul_b = st_ff; end
               3'd2: begin mul_a = ca_ff;  mul_b = ct_ff; end
               3'd3: begin mul_a = -sa_ff; mul_b = ct_ff; end
               3'd4: begin mul_a = MW'(a_ff); mul_b = ct_ff; end
               default: begin mul_a = MW'(a_ff); mul_b = st_ff; end
            endcase
         end
         dhfk_pkg::OP_MLO: begin
            mul_a = signed'(cm_rd[MW-1:0]);
            mul_b = signed'({9'b0, lk_rd[23:0]});
         end
         dhfk_pkg::OP_MHI: begin
            mul_a = signed'(cm_rd[MW-1:0]);
            mul_b = MW'(signed'(lk_rd[EW-1:24]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Phase of a full turn and quadrant split
   assign ph     = prod_ff[FRAC_BITS+31:FRAC_BITS];
   assign ph_off = ph + 32'h2000_0000;

   // One CORDIC rotation step
   assign xs = x_ff >>> cmd.step;
   assign ys = y_ff >>> cmd.step;
   assign at = dhfk_pkg::atan_q30(cmd.step);

   // Undo the quadrant fold
   always_comb begin
      case (quad_ff)
         2'd0:    begin c_q = x_ff;  s_q = y_ff;  end
         2'd1:    begin c_q = -y_ff; s_q = x_ff;  end
         2'd2:    begin c_q = -x_ff; s_q = -y_ff; end
         default: begin c_q = y_ff;  s_q = -x_ff; end
      endcase
   end

   // Round a trig product into the link matrix
   assign lkw_val = (cmd.n < 3'd4) ? EW'((prod_ff + HALF_36) >>> 36)
                                   : EW'((prod_ff + HALF_A) >>> SH_A);

   // Accumulate one rounded term, and saturate a finished entry
   assign acc_in = ((cmd.v == 2'd0) ? '0 : acc_ff) + AW'(prod_ff) + AW'(lornd_ff);
   assign wr_sum = acc_ff + ((cmd.j == 2'd3) ? AW'(cm_rd) : '0);

   always_comb begin
      if (cmd.j == 2'd3) begin
         if (wr_sum > dhfk_pkg::S48_MAX) begin
            wr_val = EW'(dhfk_pkg::S48_MAX);
         end else if (wr_sum < dhfk_pkg::S48_MIN) begin
            wr_val = EW'(dhfk_pkg::S48_MIN);
         end else begin
            wr_val = EW'(wr_sum);
         end
      end else begin
         if (wr_sum > dhfk_pkg::ROT_MAX) begin
            wr_val = EW'(dhfk_pkg::ROT_MAX);
         end else if (wr_sum < dhfk_pkg::ROT_MIN) begin
            wr_val = EW'(dhfk_pkg::ROT_MIN);
         end else begin
            wr_val = EW'(wr_sum);
         end
      end
   end

   // Round and saturate the translation column
   always_comb begin
      logic signed [EW:0] t;
      for (int k = 0; k < 3; k++) begin
         t = ((EW + 1)'(cm_ff[k*4+3]) + HALF_O) >>> SH_D;
         if (t > P32_MAX) begin
            pos[k] = 32'sh7FFF_FFFF;
         end else if (t < P32_MIN) begin
            pos[k] = 32'sh8000_0000;
         end else begin
            pos[k] = 32'(t);
         end
      end
   end

   assign out_fire     = (cmd.op == dhfk_pkg::OP_OUT) && (!rsp_valid_ff || rsp_ready);
   assign sts.out_fire = out_fire;
   assign sts.last     = last_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   // Datapath payload registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (cmd.load) begin
         last_ff <= req_data.last_link;
         if (req_data.joint_type) begin
            alpha_ff <= req_data.first_param;
            a_ff     <= req_data.second_param;
            d_ff     <= req_data.third_param;
            theta_ff <= req_data.joint_value;
         end else begin
            theta_ff <= req_data.first_param;
            alpha_ff <= req_data.second_param;
            a_ff     <= req_data.third_param;
            d_ff     <= req_data.joint_value;
         end
      end
      case (cmd.op)
         dhfk_pkg::OP_RED: begin
            quad_ff <= ph_off[31:30];
            rr_ff   <= 31'(signed'({2'b00, ph_off[29:0]}) - 32'sd536870912);
         end
         dhfk_pkg::OP_ZSET: begin
            z_ff <= MW'(prod_ff >>> 30);
            x_ff <= dhfk_pkg::CORDIC_GAIN_Q30;
            y_ff <= '0;
         end
         dhfk_pkg::OP_ROT: begin
            if (!z_ff[MW-1]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
         end
         dhfk_pkg::OP_TRIG: begin
            if (cmd.sel) begin
               ca_ff <= c_q;
               sa_ff <= s_q;
            end else begin
               ct_ff <= c_q;
               st_ff <= s_q;
            end
         end
         dhfk_pkg::OP_LKD: begin
            lk_ff[0]  <= EW'((ct_ff + HALF_6) >>> 6);
            lk_ff[4]  <= EW'((st_ff + HALF_6) >>> 6);
            lk_ff[8]  <= '0;
            lk_ff[9]  <= EW'((sa_ff + HALF_6) >>> 6);
            lk_ff[10] <= EW'((ca_ff + HALF_6) >>> 6);
            lk_ff[11] <= EW'(d_ff) <<< SH_D;
         end
         dhfk_pkg::OP_LKW: begin
            case (cmd.n)
               3'd0:    lk_ff[1] <= lkw_val;
               3'd1:    lk_ff[2] <= lkw_val;
               3'd2:    lk_ff[5] <= lkw_val;
               3'd3:    lk_ff[6] <= lkw_val;
               3'd4:    lk_ff[3] <= lkw_val;
               default: lk_ff[7] <= lkw_val;
            endcase
         end
         dhfk_pkg::OP_MHI: lornd_ff <= EW'((prod_ff + HALF_24) >>> 24);
         dhfk_pkg::OP_ACC: acc_ff <= acc_in;
         dhfk_pkg::OP_WR:  row_ff[cmd.j] <= wr_val;
         default: ;
      endcase
      if (out_fire) begin
         rsp_ff.pos_x <= pos[0];
         rsp_ff.pos_y <= pos[1];
         rsp_ff.pos_z <= pos[2];
      end
   end

   // Running product: write back a row, or return to identity on reset or after a result
   always_ff @(posedge clock) begin
      if (reset || out_fire) begin
         for (int k = 0; k < 12; k++) begin
            cm_ff[k] <= ((k % 5) == 0 && k < 11) ? dhfk_pkg::ONE_Q24 : '0;
         end
      end else if (cmd.op == dhfk_pkg::OP_CP) begin
         for (int k = 0; k < 4; k++) begin
            cm_ff[{cmd.i, 2'(k)}] <= row_ff[k];
         end
      end
   end

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dh_forward_kinematics_chain_top.sv -----
// Links are taken one at a time: ready stays low from accept until the link is done,
// and a last link also loads the result beat before ready returns. The single shared
// 33x33 multiplier serves angle reduction, link matrix and all 36 products.
// Reset: synchronous, active high; clears the controller, the result beat and
// returns the running product to identity.
`timescale 1ns / 1ps
`default_nettype none

module dh_forward_kinematics_chain_top #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dhfk_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dhfk_pkg::rsp_type      rsp_data
);

   dhfk_pkg::cmd_type cmd;
   dhfk_pkg::sts_type sts;

   dhfk_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   dhfk_dp #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // An accepted link keeps the block busy for the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a link was accepted");

   // A result beat appears only from the output step
   a_rsp_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(sts.out_fire))
      else $error("result beat raised without an output step");

   // The output step always produces a beat
   a_fire_sets_valid: assert property (@(posedge clock) disable iff (reset)
      sts.out_fire |=> rsp_valid)
      else $error("output step did not present a result beat");

   // Output step only runs while no link is being taken
   a_fire_not_idle: assert property (@(posedge clock) disable iff (reset)
      sts.out_fire |-> !req_ready)
      else $error("output step while the block is idle");

endmodule

`default_nettype wire
